// ===== hw/rtl/tte_pkg.sv =====
// Shared constants and a helper for the token table name expander.
package tte_pkg;

  localparam int TABLE_BYTES = 4096;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);
  localparam int INDEX_DEPTH = 256;
  localparam int MAX_TOKEN   = 32;
  localparam int TOK_CW      = $clog2(MAX_TOKEN + 1);

  localparam logic [1:0] FUNC_TABLE = 2'd0;
  localparam logic [1:0] FUNC_INDEX = 2'd1;
  localparam logic [1:0] FUNC_NAME  = 2'd2;

  localparam logic [7:0] NAME_LEN_RESET = 8'd128;
  localparam logic [7:0] NAME_LEN_CAP   = 8'd128;

  // Buffer size as used: zero acts as one, anything above the cap acts as the cap.
  function automatic logic [7:0] clamp_limit(input logic [7:0] len);
    logic [7:0] res;
    res = len;
    if (len == 8'd0) begin
      res = 8'd1;
    end else if (len > NAME_LEN_CAP) begin
      res = NAME_LEN_CAP;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/token_table_name_expander.sv =====
// Top level of the token table name expander: parser, token walker and output register.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | func, table_addr, table_byte, index_slot,
//           |           |                     | index_value, name_byte
//   out     | output    | out_valid/out_stall | out_char, name_end, token_overflow
//   cfg     | input     | cfg_we              | cfg_wdata (max_name_len)
//
// Load requests, length bytes and unused function codes do not start a token walk.
// A code byte is expanded by walking its token twice through the one read port of the
// token table memory, a read state and a check state per byte, first to find its length
// and then to emit it. A closing terminator is sent from a state of its own.
// Reset is synchronous; the stores are not cleared and must be written before use.
// A stall on the output holds the walker on the pending character; a new request is
// taken only when the walker is idle, even while a result still waits to be taken.
module token_table_name_expander
  import tte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [11:0] table_addr,
  input  logic [7:0]  table_byte,
  input  logic [7:0]  index_slot,
  input  logic [11:0] index_value,
  input  logic [7:0]  name_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        name_end,
  output logic        token_overflow,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INDEX    = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_CHK = 3'd5;
  localparam logic [2:0] S_TERM     = 3'd6;

  localparam logic [1:0] PH_LEN   = 2'd0;
  localparam logic [1:0] PH_LEN2  = 2'd1;
  localparam logic [1:0] PH_CODES = 2'd2;

  logic [2:0]          state;
  logic [1:0]          phase;
  logic [14:0]         codes_rem;
  logic                first_skipped;
  logic [6:0]          chars_written;
  logic [7:0]          max_name_len;
  logic [TABLE_AW-1:0] tok_start;
  logic [TOK_CW-1:0]   tok_i;
  logic                tok_ovf;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic [7:0]          out_char_next;
  logic                name_end_next;
  logic [7:0]          limit;
  logic                room_left;
  logic                tok_done;
  logic [14:0]         len2;
  logic [14:0]         codes_dec;

  logic                tbl_we;
  logic [TABLE_AW-1:0] tbl_raddr;
  logic [7:0]          tbl_rdata;
  logic                idx_we;
  logic [TABLE_AW-1:0] idx_rdata;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign limit     = clamp_limit(max_name_len);
  assign room_left = ({1'b0, chars_written} + 8'd1) < limit;
  assign tok_done  = (tok_i == TOK_CW'(MAX_TOKEN)) || (tbl_rdata == 8'd0);
  assign len2      = {name_byte, codes_rem[6:0]};
  assign codes_dec = codes_rem - 15'd1;

  assign tbl_we    = in_accept && (func == FUNC_TABLE);
  assign idx_we    = in_accept && (func == FUNC_INDEX);
  assign tbl_raddr = tok_start + TABLE_AW'(tok_i);

  tte_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (table_addr[TABLE_AW-1:0]),
    .wdata (table_byte),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // The index read address follows the input byte, so the entry is ready in the cycle
  // after a code byte is accepted.
  tte_ram #(.WIDTH(TABLE_AW), .DEPTH(INDEX_DEPTH)) u_index (
    .clk   (clk),
    .we    (idx_we),
    .waddr (index_slot),
    .wdata (index_value[TABLE_AW-1:0]),
    .raddr (name_byte),
    .rdata (idx_rdata)
  );

  always_comb begin
    out_load      = 1'b0;
    out_char_next = tbl_rdata;
    name_end_next = 1'b0;
    if (state == S_TERM && out_free) begin
      out_load      = 1'b1;
      out_char_next = 8'd0;
      name_end_next = 1'b1;
    end else if (state == S_EMIT_CHK && !tok_done && first_skipped && room_left
                 && out_free) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_char       <= out_char_next;
      name_end       <= name_end_next;
      token_overflow <= name_end_next ? 1'b0 : tok_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_len <= NAME_LEN_RESET;
    end else if (cfg_we) begin
      max_name_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_LEN;
      codes_rem     <= '0;
      first_skipped <= 1'b0;
      chars_written <= '0;
      tok_i         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept && func == FUNC_NAME) begin
            unique case (phase)
              PH_LEN: begin
                if (name_byte[7]) begin
                  codes_rem <= {8'd0, name_byte[6:0]};
                  phase     <= PH_LEN2;
                end else if (name_byte == 8'd0) begin
                  state <= S_TERM;
                end else begin
                  codes_rem <= {8'd0, name_byte[6:0]};
                  phase     <= PH_CODES;
                end
              end
              PH_LEN2: begin
                codes_rem <= len2;
                if (len2 == 15'd0) begin
                  state <= S_TERM;
                end else begin
                  phase <= PH_CODES;
                end
              end
              default: begin
                state <= S_INDEX;
              end
            endcase
          end
        end
        S_INDEX: begin
          tok_i <= '0;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          // A token is cut only when no terminator shows up within its first
          // MAX_TOKEN bytes and the byte just past them is nonzero.
          if (tok_i == TOK_CW'(MAX_TOKEN) || tbl_rdata == 8'd0) begin
            tok_i <= '0;
            state <= S_EMIT_RD;
          end else begin
            tok_i <= tok_i + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_CHK;
        end
        S_EMIT_CHK: begin
          if (tok_done) begin
            codes_rem <= codes_dec;
            state     <= (codes_dec == 15'd0) ? S_TERM : S_IDLE;
          end else if (!first_skipped) begin
            first_skipped <= 1'b1;
            tok_i         <= tok_i + 1'b1;
            state         <= S_EMIT_RD;
          end else if (!room_left) begin
            tok_i <= tok_i + 1'b1;
            state <= S_EMIT_RD;
          end else if (out_free) begin
            chars_written <= chars_written + 7'd1;
            tok_i         <= tok_i + 1'b1;
            state         <= S_EMIT_RD;
          end
        end
        S_TERM: begin
          if (out_free) begin
            phase         <= PH_LEN;
            codes_rem     <= '0;
            first_skipped <= 1'b0;
            chars_written <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INDEX) begin
      tok_start <= idx_rdata;
    end
    if (state == S_SCAN_CHK) begin
      tok_ovf <= (tok_i == TOK_CW'(MAX_TOKEN)) && (tbl_rdata != 8'd0);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while a result is stalled");

  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_end) |-> (!token_overflow && out_char == 8'd0))
    else $error("terminator carries a character or an overflow flag");

  a_tok_bound: assert property (@(posedge clk) disable iff (rst)
    tok_i <= TOK_CW'(MAX_TOKEN))
    else $error("token walk ran past the maximum token length");

  a_codes_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_INDEX) |-> (codes_rem != 15'd0 && phase == PH_CODES))
    else $error("code byte expanded outside of a name body");

  a_term_reset: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM && out_free) |=> (phase == PH_LEN && chars_written == 7'd0))
    else $error("name state not cleared after the terminator");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for token_table_name_expander: dictionary loads, name streams, checks.
`timescale 1ns / 1ps

module tb
  import tte_pkg::*;
();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Length byte encoding.
  localparam logic [7:0] LEN_LONG       = 8'h80;
  localparam logic [7:0] LEN_LOW_MASK   = 8'h7F;
  localparam int         LEN_HIGH_SHIFT = 7;

  // Code slots that point at the hand-built tokens of the dictionary.
  localparam logic [7:0] CODE_WRAP   = 8'd2;
  localparam logic [7:0] CODE_SINGLE = 8'd3;
  localparam logic [7:0] CODE_LONG   = 8'd9;
  localparam logic [7:0] CODE_EXACT  = 8'd10;
  localparam logic [7:0] CODE_EMPTY  = 8'd11;
  localparam logic [7:0] CODE_TOP    = 8'hFF;
  localparam int         FIXED_CODES = 12;

  // Random table writes land here, away from the hand-built dictionary.
  localparam logic [11:0] SCRATCH_BASE  = 12'd2048;
  localparam int          SCRATCH_BYTES = 16;

  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 2000;

  typedef enum logic [1:0] {WANT_LEN, WANT_LEN_HIGH, WANT_CODES} parse_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       closing;
    logic       cut;
  } name_char_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  tbyte;
    logic [7:0]  slot;
    logic [11:0] start;
    logic [7:0]  nbyte;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_UNUSED;
  logic [11:0] table_addr = '0;
  logic [7:0]  table_byte = '0;
  logic [7:0]  index_slot = '0;
  logic [11:0] index_value = '0;
  logic [7:0]  name_byte = '0;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char;
  logic        name_end;
  logic        token_overflow;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  logic sink_stall = 1'b0;
  logic hold_off = 1'b0;
  assign out_stall = sink_stall | hold_off;

  token_table_name_expander uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .table_addr(table_addr), .table_byte(table_byte),
    .index_slot(index_slot), .index_value(index_value), .name_byte(name_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .name_end(name_end), .token_overflow(token_overflow),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the dictionary and the name parser.
  logic [7:0]  dict_mem [0:TABLE_BYTES-1];
  bit          dict_set [0:TABLE_BYTES-1];
  logic [11:0] code_start [0:INDEX_DEPTH-1];
  bit          code_set [0:INDEX_DEPTH-1];
  parse_t      parse_state = WANT_LEN;
  logic [14:0] codes_left = '0;
  bit          type_dropped = 1'b0;
  int          name_chars = 0;
  logic [7:0]  name_limit = NAME_LEN_RESET;

  name_char_t  pending_chars [$];
  logic [11:0] tok_list [$];
  logic [11:0] load_addr;

  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int hold_request = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int reqs_sent = 0;
  int chars_checked = 0;
  int names_checked = 0;
  int cut_chars = 0;

  function automatic void close_name();
    name_char_t nc;
    nc = {8'h00, 1'b1, 1'b0};
    pending_chars.push_back(nc);
    parse_state = WANT_LEN;
    codes_left = '0;
    type_dropped = 1'b0;
    name_chars = 0;
  endfunction

  function automatic void open_codes(input logic [14:0] len);
    codes_left = len;
    if (len == 15'd0) close_name();
    else parse_state = WANT_CODES;
  endfunction

  function automatic void expand_code(input logic [7:0] code);
    logic [11:0] base, a;
    logic [7:0]  lim, ch;
    logic        cut;
    bit          ended;
    name_char_t  nc;
    int          i;
    base = code_start[code];
    if (name_limit == 8'd0) lim = 8'd1;
    else if (name_limit > NAME_LEN_CAP) lim = NAME_LEN_CAP;
    else lim = name_limit;
    // A token is cut when no terminator shows up in its first MAX_TOKEN bytes
    // and the byte right after them is not a terminator either.
    ended = 1'b0;
    for (i = 0; i < MAX_TOKEN && !ended; i++) begin
      a = base + 12'(i);
      if (dict_mem[a] == 8'd0) ended = 1'b1;
    end
    a = base + 12'(MAX_TOKEN);
    cut = !ended && (dict_mem[a] != 8'd0);
    ended = 1'b0;
    for (i = 0; i < MAX_TOKEN && !ended; i++) begin
      a = base + 12'(i);
      ch = dict_mem[a];
      if (ch == 8'd0) begin
        ended = 1'b1;
      end else if (!type_dropped) begin
        type_dropped = 1'b1;
      end else if (name_chars + 1 < int'(lim)) begin
        nc = {ch, 1'b0, cut};
        pending_chars.push_back(nc);
        name_chars++;
      end
    end
    codes_left = codes_left - 15'd1;
    if (codes_left == 15'd0) close_name();
  endfunction

  function automatic void expand_request(input req_t r);
    logic [14:0] wide;
    case (r.func)
      FUNC_TABLE: begin
        dict_mem[r.addr] = r.tbyte;
        dict_set[r.addr] = 1'b1;
      end
      FUNC_INDEX: begin
        code_start[r.slot] = r.start;
        code_set[r.slot] = 1'b1;
      end
      FUNC_NAME: begin
        case (parse_state)
          WANT_LEN: begin
            if ((r.nbyte & LEN_LONG) != 8'd0) begin
              codes_left = {7'd0, r.nbyte & LEN_LOW_MASK};
              parse_state = WANT_LEN_HIGH;
            end else begin
              open_codes({7'd0, r.nbyte});
            end
          end
          WANT_LEN_HIGH: begin
            wide = {r.nbyte, codes_left[6:0]};
            open_codes(wide);
          end
          default: expand_code(r.nbyte);
        endcase
      end
      default: ;
    endcase
  endfunction

  // A code is usable only when every table byte its walk touches was loaded.
  function automatic bit code_ok(input logic [7:0] code);
    logic [11:0] a;
    bit ok, ended;
    int i;
    ok = code_set[code];
    ended = 1'b0;
    for (i = 0; i <= MAX_TOKEN && ok && !ended; i++) begin
      a = code_start[code] + 12'(i);
      if (!dict_set[a]) ok = 1'b0;
      else if (dict_mem[a] == 8'd0) ended = 1'b1;
    end
    return ok;
  endfunction

  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (!code_ok(c)) c = 8'($urandom_range(0, FIXED_CODES - 1));
    return c;
  endfunction

  function automatic req_t filler_req();
    req_t r;
    r.func  = FUNC_UNUSED;
    r.addr  = 12'($urandom);
    r.tbyte = 8'($urandom);
    r.slot  = 8'($urandom);
    r.start = 12'($urandom);
    r.nbyte = 8'($urandom);
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    gap = src_idle ? int'($urandom_range(0, 7)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= r.func;
    table_addr  <= r.addr;
    table_byte  <= r.tbyte;
    index_slot  <= r.slot;
    index_value <= r.start;
    name_byte   <= r.nbyte;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expand_request(r);
    if (r.func != FUNC_UNUSED) reqs_sent++;
  endtask

  task automatic send_table(input logic [11:0] a, input logic [7:0] b);
    req_t r;
    r = filler_req();
    r.func = FUNC_TABLE;
    r.addr = a;
    r.tbyte = b;
    send_req(r);
  endtask

  task automatic send_index(input logic [7:0] s, input logic [11:0] v);
    req_t r;
    r = filler_req();
    r.func = FUNC_INDEX;
    r.slot = s;
    r.start = v;
    send_req(r);
  endtask

  task automatic send_name_byte(input logic [7:0] b);
    req_t r;
    r = filler_req();
    r.func = FUNC_NAME;
    r.nbyte = b;
    send_req(r);
  endtask

  task automatic send_length(input logic [14:0] len, input bit long_form);
    if (long_form || len > 15'(LEN_LOW_MASK)) begin
      send_name_byte(LEN_LONG | {1'b0, len[6:0]});
      send_name_byte(8'(len >> LEN_HIGH_SHIFT));
    end else begin
      send_name_byte(len[7:0]);
    end
  endtask

  // Stop offering requests, let every character arrive, then give the walker
  // time to finish a code whose characters were all dropped.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_name_limit(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    name_limit = v;
  endtask

  task automatic put_token(input int len);
    int i;
    tok_list.push_back(load_addr);
    for (i = 0; i < len; i++) begin
      send_table(load_addr, 8'($urandom_range(1, 255)));
      load_addr++;
    end
    send_table(load_addr, 8'h00);
    load_addr++;
  endtask

  task automatic test_load_dictionary();
    int i;
    // The region starts near the top of the table so that one token wraps.
    load_addr = 12'd4086;
    put_token(3);
    put_token(4);
    put_token(3);
    put_token(1);
    for (i = 4; i < int'(CODE_LONG); i++) put_token($urandom_range(1, 2));
    // The cut token is one byte longer than the token that just fits and runs into it.
    tok_list.push_back(load_addr);
    send_table(load_addr, 8'($urandom_range(1, 255)));
    load_addr++;
    put_token(MAX_TOKEN);
    put_token(0);
    for (i = 0; i < FIXED_CODES; i++) send_index(8'(i), tok_list[i]);
    send_index(CODE_TOP, tok_list[1]);
    settle();
  endtask

  task automatic test_directed_names();
    src_idle = 1'b0;
    send_length(15'd0, 1'b0);
    send_length(15'd0, 1'b1);
    // The single-character token is used up as the type letter.
    send_length(15'd3, 1'b0);
    send_name_byte(CODE_SINGLE);
    send_name_byte(CODE_WRAP);
    send_name_byte(CODE_EMPTY);
    // The type letter comes from a cut token, then a token that just fits.
    send_length(15'd2, 1'b0);
    send_name_byte(CODE_LONG);
    send_name_byte(CODE_EXACT);
    send_req(filler_req());
    src_idle = 1'b1;
    send_length(15'd2, 1'b1);
    send_name_byte(8'h00);
    send_name_byte(CODE_TOP);
    settle();
  endtask

  task automatic test_name_limits();
    logic [7:0] lim;
    int k;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: lim = 8'd0;
        1: lim = 8'd1;
        2: lim = 8'd2;
        3: lim = 8'd40;
        4: lim = 8'd255;
        default: lim = NAME_LEN_CAP;
      endcase
      set_name_limit(lim);
      send_length(15'd3, 1'b0);
      send_name_byte(CODE_LONG);
      send_name_byte(CODE_EXACT);
      send_name_byte(CODE_WRAP);
      settle();
    end
  endtask

  // Enough long tokens to run past the largest buffer size.
  task automatic test_long_name();
    int k;
    set_name_limit(NAME_LEN_CAP);
    send_length(15'd6, 1'b1);
    for (k = 0; k < 6; k++) send_name_byte((k % 2 == 0) ? CODE_EXACT : CODE_LONG);
    settle();
  endtask

  task automatic test_backpressure();
    int k;
    src_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    send_length(15'd10, 1'b0);
    for (k = 0; k < 10; k++) send_name_byte(pick_code());
    src_idle = 1'b1;
    // The sender now waits until the whole name has come out.
    settle();
  endtask

  task automatic send_random_load();
    logic [11:0] v;
    if ($urandom_range(0, 1) == 0) begin
      send_table(SCRATCH_BASE + 12'($urandom_range(0, SCRATCH_BYTES - 1)),
                 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1) == 0) v = SCRATCH_BASE + 12'($urandom_range(0, SCRATCH_BYTES - 1));
      else v = tok_list[$urandom_range(0, tok_list.size() - 1)];
      send_index(8'($urandom_range(FIXED_CODES, INDEX_DEPTH - 2)), v);
    end
  endtask

  task automatic test_random_traffic();
    int phase, budget, len, k;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_name_limit(8'($urandom_range(2, 16)));
        1: set_name_limit(8'($urandom_range(17, 127)));
        default: set_name_limit(NAME_LEN_RESET);
      endcase
      budget = reqs_sent + 10;
      while (reqs_sent < budget) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0: send_req(filler_req());
          1: send_random_load();
          default: begin
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(6, 10))
                                              : int'($urandom_range(0, 4));
            send_length(15'(len), $urandom_range(0, 7) == 0);
            for (k = 0; k < len; k++) begin
              // Loads and unused requests may land in the middle of a name.
              case ($urandom_range(0, 15))
                0: send_random_load();
                1: send_req(filler_req());
                default: ;
              endcase
              send_name_byte(pick_code());
            end
          end
        endcase
      end
      src_idle = 1'b1;
      sink_idle = 1'b1;
      settle();
    end
  endtask

  initial begin : result_sink
    int pause;
    name_char_t got, want;
    forever begin
      pause = sink_idle ? int'($urandom_range(0, 7)) : 0;
      if (pause != 0) begin
        sink_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      sink_stall <= 1'b0;
      @(posedge clk);
      while (!(!rst && out_valid === 1'b1 && out_stall == 1'b0)) @(posedge clk);
      got = {out_char, name_end, token_overflow};
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character chr=%h end=%b cut=%b with none pending",
                   got.chr, got.closing, got.cut);
      end else begin
        want = pending_chars.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("character %0d: expected chr=%h end=%b cut=%b, got chr=%h end=%b cut=%b",
                     chars_checked, want.chr, want.closing, want.cut,
                     got.chr, got.closing, got.cut);
        end
      end
      chars_checked++;
      if (got.closing === 1'b1) names_checked++;
      if (got.cut === 1'b1) cut_chars++;
    end
  end

  initial begin : output_hold
    forever begin
      wait (hold_request != 0);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (hold_request) @(posedge clk);
      hold_off <= 1'b0;
      hold_request = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && !((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles == STALL_LIMIT) begin
      $display("token_table_name_expander: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_load_dictionary();
    test_directed_names();
    test_name_limits();
    test_long_name();
    test_backpressure();
    test_random_traffic();
    if (pending_chars.size() != 0) mismatches++;
    $display("Sent %0d requests; checked %0d characters in %0d names, %0d from cut tokens.",
             reqs_sent, chars_checked, names_checked, cut_chars);
    $display("Name limits from 0 to 255, wrapped and empty tokens, stalls on both sides.");
    if (mismatches == 0) begin
      $display("token_table_name_expander: match");
    end else begin
      $display("token_table_name_expander: mismatch");
    end
    $finish;
  end

endmodule
